// File: hw/rtl/srtq_pkg.sv
// Package for the sorted repeating timer queue.
// Holds operation, result, command and sequencer state codes, the shared constants and a saturating add.
// No dependencies.
package srtq_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned PerW  = 24;
  localparam int unsigned RepW  = 17;
  localparam logic [TimeW-1:0] TimeMax = '1;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_ADJUST  = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    K_CREATED  = 3'd0,
    K_FULL     = 3'd1,
    K_DONE     = 3'd2,
    K_NOTFOUND = 3'd3,
    K_FIRED    = 3'd4,
    K_WAIT     = 3'd5
  } kind_e;

  // Repeat counts are held 17 bits wide; -2 means forever.
  localparam logic signed [RepW-1:0] RepForever = -17'sd2;

  // Command broadcast to all cells of the chain together.
  typedef enum logic [2:0] {
    C_NONE   = 3'd0,
    C_INSERT = 3'd1,
    C_REMOVE = 3'd2,
    C_CLRFC  = 3'd3
  } cmd_e;

  // States of the sequencer in the top level.
  typedef enum logic [3:0] {
    S_IDLE, S_CPROBE, S_CCHK, S_FIND, S_RM, S_INS, S_TSRCH, S_TRM, S_TINS,
    S_CLR, S_OUT
  } st_e;

  function automatic logic [TimeW-1:0] sat_add(input logic [TimeW-1:0] a,
                                               input logic [TimeW-1:0] b);
    logic [TimeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeW] ? TimeMax : s[TimeW-1:0];
  endfunction

endpackage

// File: hw/rtl/srtq_cell.sv
// One slot of the timer chain: holds a timer and shifts with its neighbors.
// Depends on srtq_pkg.
module srtq_cell #(
  parameter int unsigned IdW = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  srtq_pkg::cmd_e                cmd_i,
  input  logic [srtq_pkg::TimeW-1:0]    key_i,     // expiry of new entry
  input  logic                          rm_here_i, // this cell is removed
  input  logic                          rm_before_i, // removal at lower slot
  input  logic                          ins_before_i, // insert at lower slot
  // new entry
  input  logic [IdW-1:0]                n_id_i,
  input  logic signed [srtq_pkg::RepW-1:0] n_rep_i,
  input  logic [srtq_pkg::PerW-1:0]     n_per_i,
  input  logic [1:0]                    n_fc_i,
  // left neighbor
  input  logic                          l_valid_i,
  input  logic [IdW-1:0]                l_id_i,
  input  logic signed [srtq_pkg::RepW-1:0] l_rep_i,
  input  logic [srtq_pkg::PerW-1:0]     l_per_i,
  input  logic [srtq_pkg::TimeW-1:0]    l_exp_i,
  input  logic [1:0]                    l_fc_i,
  // right neighbor
  input  logic                          r_valid_i,
  input  logic [IdW-1:0]                r_id_i,
  input  logic signed [srtq_pkg::RepW-1:0] r_rep_i,
  input  logic [srtq_pkg::PerW-1:0]     r_per_i,
  input  logic [srtq_pkg::TimeW-1:0]    r_exp_i,
  input  logic [1:0]                    r_fc_i,
  output logic                          valid_o,
  output logic                          after_o,   // expiry greater than key
  output logic [IdW-1:0]                id_o,
  output logic signed [srtq_pkg::RepW-1:0] rep_o,
  output logic [srtq_pkg::PerW-1:0]     per_o,
  output logic [srtq_pkg::TimeW-1:0]    exp_o,
  output logic [1:0]                    fc_o
);

  logic                              valid_q, valid_d;
  logic [IdW-1:0]                    id_q, id_d;
  logic signed [srtq_pkg::RepW-1:0]  rep_q, rep_d;
  logic [srtq_pkg::PerW-1:0]         per_q, per_d;
  logic [srtq_pkg::TimeW-1:0]        exp_q, exp_d;
  logic [1:0]                        fc_q, fc_d;
  logic                              ins_here;

  assign after_o  = valid_q && (exp_q > key_i);
  // The first cell that is after the key, or the first empty one, takes the entry.
  assign ins_here = !ins_before_i && (after_o || !valid_q);

  always_comb begin
    valid_d = valid_q; id_d = id_q; rep_d = rep_q;
    per_d = per_q; exp_d = exp_q; fc_d = fc_q;
    case (cmd_i)
      srtq_pkg::C_INSERT: begin
        if (ins_before_i) begin
          valid_d = l_valid_i; id_d = l_id_i; rep_d = l_rep_i;
          per_d = l_per_i; exp_d = l_exp_i; fc_d = l_fc_i;
        end else if (ins_here) begin
          valid_d = 1'b1; id_d = n_id_i; rep_d = n_rep_i;
          per_d = n_per_i; exp_d = key_i; fc_d = n_fc_i;
        end
      end
      srtq_pkg::C_REMOVE: begin
        if (rm_here_i || rm_before_i) begin
          valid_d = r_valid_i; id_d = r_id_i; rep_d = r_rep_i;
          per_d = r_per_i; exp_d = r_exp_i; fc_d = r_fc_i;
        end
      end
      srtq_pkg::C_CLRFC: fc_d = 2'd0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d; rep_q <= rep_d; per_q <= per_d; exp_q <= exp_d; fc_q <= fc_d;
  end

  assign valid_o = valid_q;
  assign id_o    = id_q;
  assign rep_o   = rep_q;
  assign per_o   = per_q;
  assign exp_o   = exp_q;
  assign fc_o    = fc_q;

endmodule

// File: hw/rtl/srtq_chain.sv
// Row of SLOTS timer cells kept in expiry order, with the per-cell flags
// that locate inserts, removals, id matches and due timers. Uses srtq_cell, srtq_pkg.
module srtq_chain #(
  parameter int unsigned Slots = 16,
  parameter int unsigned IdW   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  srtq_pkg::cmd_e                   cmd_i,
  input  logic [srtq_pkg::TimeW-1:0]       key_i,
  input  logic [$clog2(Slots)-1:0]         rm_pos_i,
  input  logic [IdW-1:0]                   n_id_i,
  input  logic signed [srtq_pkg::RepW-1:0] n_rep_i,
  input  logic [srtq_pkg::PerW-1:0]        n_per_i,
  input  logic [1:0]                       n_fc_i,
  input  logic [IdW-1:0]                   match_id_i,
  input  logic [srtq_pkg::TimeW-1:0]       now_i,
  output logic                             full_o,
  output logic                             empty_o,
  output logic                             found_o,
  output logic [$clog2(Slots)-1:0]         found_pos_o,
  output logic                             due_o,
  output logic [$clog2(Slots)-1:0]         due_pos_o,
  output logic [IdW-1:0]                   due_id_o,
  output logic signed [srtq_pkg::RepW-1:0] due_rep_o,
  output logic [srtq_pkg::PerW-1:0]        due_per_o,
  output logic [srtq_pkg::TimeW-1:0]       due_exp_o,
  output logic [1:0]                       due_fc_o,
  output logic [srtq_pkg::TimeW-1:0]       head_exp_o
);

  localparam int unsigned PosW = $clog2(Slots);

  logic                             v   [Slots+1];
  logic [IdW-1:0]                   ids [Slots+1];
  logic signed [srtq_pkg::RepW-1:0] reps[Slots+1];
  logic [srtq_pkg::PerW-1:0]        pers[Slots+1];
  logic [srtq_pkg::TimeW-1:0]       exps[Slots+1];
  logic [1:0]                       fcs [Slots+1];
  logic [Slots-1:0]                 after;
  logic [Slots:0]                   ins_pre;
  logic [Slots:0]                   rm_pre;

  // Past-the-end neighbor is empty.
  assign v[Slots]    = 1'b0;
  assign ids[Slots]  = '0;
  assign reps[Slots] = '0;
  assign pers[Slots] = '0;
  assign exps[Slots] = '0;
  assign fcs[Slots]  = '0;

  assign ins_pre[0] = 1'b0;
  assign rm_pre[0]  = 1'b0;

  for (genvar g = 0; g < Slots; g++) begin : g_cell
    logic rm_here;
    logic ins_here;
    assign rm_here      = (rm_pos_i == PosW'(g));
    assign ins_here     = after[g] || !v[g];
    assign ins_pre[g+1] = ins_pre[g] || ins_here;
    assign rm_pre[g+1]  = rm_pre[g] || rm_here;

    srtq_cell #(.IdW(IdW)) u_cell (
      .clk_i, .rst_ni, .cmd_i, .key_i,
      .rm_here_i   (rm_here),
      .rm_before_i (rm_pre[g]),
      .ins_before_i(ins_pre[g]),
      .n_id_i, .n_rep_i, .n_per_i, .n_fc_i,
      .l_valid_i (g == 0 ? 1'b0 : v[(g == 0) ? 0 : g-1]),
      .l_id_i    (ids[(g == 0) ? 0 : g-1]),
      .l_rep_i   (reps[(g == 0) ? 0 : g-1]),
      .l_per_i   (pers[(g == 0) ? 0 : g-1]),
      .l_exp_i   (exps[(g == 0) ? 0 : g-1]),
      .l_fc_i    (fcs[(g == 0) ? 0 : g-1]),
      .r_valid_i (v[g+1]),
      .r_id_i    (ids[g+1]),
      .r_rep_i   (reps[g+1]),
      .r_per_i   (pers[g+1]),
      .r_exp_i   (exps[g+1]),
      .r_fc_i    (fcs[g+1]),
      .valid_o   (v[g]),
      .after_o   (after[g]),
      .id_o      (ids[g]),
      .rep_o     (reps[g]),
      .per_o     (pers[g]),
      .exp_o     (exps[g]),
      .fc_o      (fcs[g])
    );
  end

  assign full_o     = v[Slots-1];
  assign empty_o    = !v[0];
  assign head_exp_o = exps[0];

  // Priority searches over independent per-cell flags.
  always_comb begin
    found_o = 1'b0; found_pos_o = '0;
    due_o = 1'b0; due_pos_o = '0;
    for (int i = Slots-1; i >= 0; i--) begin
      if (v[i] && ids[i] == match_id_i) begin
        found_o = 1'b1; found_pos_o = PosW'(i);
      end
      if (v[i] && exps[i] <= now_i && fcs[i] != 2'd2) begin
        due_o = 1'b1; due_pos_o = PosW'(i);
      end
    end
  end

  assign due_id_o  = ids[due_pos_o];
  assign due_rep_o = reps[due_pos_o];
  assign due_per_o = pers[due_pos_o];
  assign due_exp_o = exps[due_pos_o];
  assign due_fc_o  = fcs[due_pos_o];

endmodule

// File: hw/rtl/sorted_repeating_timer_queue_core.sv
// Sorted repeating timer queue: a sequencer in front of a shifting chain of
// timer cells. Uses srtq_chain and srtq_pkg.
//
// Input beats carry mode, timer_id, repeat_count, period and now_seconds.
// Each input beat gives one or more output beats; the last one has last_item
// set. Create answers created (with the new id) or table full; destroy and
// adjust answer done or not found; tick gives a fired beat each time a due
// timer fires, in expiry order (at most twice per timer and 2*SLOTS in all),
// then a next-wait beat with the seconds to the earliest expiry. One item is
// processed at a time. A create on a full table goes straight to its result;
// other creates probe ids, with an id check per probe once the id counter has
// wrapped, then insert or answer full. A destroy finds and removes the timer;
// an adjust also inserts it anew. A tick clears the fire counts and searches
// for a due timer before each beat; a fired timer is removed and, if it is
// reloaded, inserted again. The next input is taken in the cycle after the last
// beat enters the single output register; a stalled receiver simply holds the
// sequencer until the waiting beat is taken. Reset empties the table, zeros the
// id counter and the last tick time; the block is ready right after reset.
module sorted_repeating_timer_queue_core #(
  parameter int unsigned SLOTS   = 16,
  parameter int unsigned ID_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [15:0] timer_id_i,
  input  logic signed [15:0] repeat_count_i,
  input  logic [23:0] period_i,
  input  logic [31:0] now_seconds_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [15:0] result_id_o,
  output logic [31:0] wait_seconds_o,
  output logic        last_item_o
);

  localparam int unsigned PosW = $clog2(SLOTS);
  localparam int unsigned CntW = $clog2(2*SLOTS+1);
  localparam int unsigned TryW = $clog2(SLOTS+3);
  localparam int unsigned TW   = srtq_pkg::TimeW;

  srtq_pkg::st_e st_q, st_d;

  logic [1:0]                       mode_q;
  logic [ID_BITS-1:0]               tid_q;
  logic signed [srtq_pkg::RepW-1:0] rep_q, rep_d;
  logic [srtq_pkg::PerW-1:0]        per_q, per_d;
  logic [TW-1:0]                    now_q;
  logic [TW-1:0]                    key_q, key_d;
  logic [ID_BITS-1:0]               nid_q, nid_d;
  logic [1:0]                       nfc_q, nfc_d;
  logic [ID_BITS-1:0]               ctr_q, ctr_d;
  logic                             wrap_q, wrap_d;
  logic [TW-1:0]                    ltt_q, ltt_d;
  logic [TryW-1:0]                  try_q, try_d;
  logic [CntW-1:0]                  k_q, k_d;
  logic [PosW-1:0]                  pos_q, pos_d;
  logic                             ret_out_q, ret_out_d; // return to idle after out
  srtq_pkg::st_e                    ret_q, ret_d;

  // The next beat is staged in sk/sid/sw/sl and moved to the output register in S_OUT.
  logic        ov_q, ov_d;
  logic [2:0]  sk_q, sk_d;
  logic [15:0] sid_q, sid_d;
  logic [31:0] sw_q, sw_d;
  logic        sl_q, sl_d;
  logic [2:0]  okind_q;
  logic [15:0] oid_q;
  logic [31:0] owait_q;
  logic        olast_q;

  srtq_pkg::cmd_e             cmd;
  logic [ID_BITS-1:0]         match_id;
  logic                       full, empty, found, due;
  logic [PosW-1:0]            found_pos, due_pos;
  logic [ID_BITS-1:0]         due_id;
  logic signed [srtq_pkg::RepW-1:0] due_rep;
  logic [srtq_pkg::PerW-1:0]  due_per;
  logic [TW-1:0]              due_exp, head_exp;
  logic [1:0]                 due_fc;
  logic                       in_acc;
  logic [srtq_pkg::PerW-1:0]  per_in;
  logic [ID_BITS-1:0]         ctr_nx;
  logic [TW-1:0]              nx;

  srtq_chain #(.Slots(SLOTS), .IdW(ID_BITS)) u_chain (
    .clk_i, .rst_ni,
    .cmd_i      (cmd),
    .key_i      (key_q),
    .rm_pos_i   (pos_q),
    .n_id_i     (nid_q),
    .n_rep_i    (rep_q),
    .n_per_i    (per_q),
    .n_fc_i     (nfc_q),
    .match_id_i (match_id),
    .now_i      (now_q),
    .full_o     (full),
    .empty_o    (empty),
    .found_o    (found),
    .found_pos_o(found_pos),
    .due_o      (due),
    .due_pos_o  (due_pos),
    .due_id_o   (due_id),
    .due_rep_o  (due_rep),
    .due_per_o  (due_per),
    .due_exp_o  (due_exp),
    .due_fc_o   (due_fc),
    .head_exp_o (head_exp)
  );

  assign in_ready_o = (st_q == srtq_pkg::S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign per_in     = (period_i == '0) ? srtq_pkg::PerW'(1) : period_i;
  assign match_id   = (st_q == srtq_pkg::S_CCHK) ? nid_q : tid_q;
  assign ctr_nx     = ctr_q + ID_BITS'(1);
  assign nx         = (srtq_pkg::sat_add(due_exp, TW'(due_per)) < now_q)
                      ? srtq_pkg::sat_add(now_q, TW'(due_per))
                      : srtq_pkg::sat_add(due_exp, TW'(due_per));

  always_comb begin
    st_d = st_q; rep_d = rep_q; per_d = per_q; key_d = key_q; nid_d = nid_q;
    nfc_d = nfc_q; ctr_d = ctr_q; wrap_d = wrap_q; ltt_d = ltt_q;
    try_d = try_q; k_d = k_q; pos_d = pos_q; ret_out_d = ret_out_q; ret_d = ret_q;
    ov_d = ov_q; sk_d = sk_q; sid_d = sid_q; sw_d = sw_q; sl_d = sl_q;
    cmd = srtq_pkg::C_NONE;

    if (ov_q && out_ready_i) ov_d = 1'b0;

    unique case (st_q)
      srtq_pkg::S_IDLE: begin
        if (in_acc) begin
          rep_d = repeat_count_i[15] ? srtq_pkg::RepForever
                                     : srtq_pkg::RepW'(repeat_count_i);
          per_d = per_in;
          key_d = srtq_pkg::sat_add(ltt_q, TW'(per_in));
          nfc_d = 2'd0;
          try_d = '0;
          k_d   = '0;
          unique case (srtq_pkg::op_e'(mode_i))
            srtq_pkg::OP_CREATE: st_d = full ? srtq_pkg::S_OUT : srtq_pkg::S_CPROBE;
            srtq_pkg::OP_DESTROY,
            srtq_pkg::OP_ADJUST: st_d = srtq_pkg::S_FIND;
            srtq_pkg::OP_TICK: begin
              ltt_d = now_seconds_i;
              st_d  = srtq_pkg::S_CLR;
            end
            default: st_d = srtq_pkg::S_IDLE;
          endcase
          if (srtq_pkg::op_e'(mode_i) == srtq_pkg::OP_CREATE && full) begin
            sk_d = srtq_pkg::K_FULL; sid_d = '0; sw_d = '0; sl_d = 1'b1;
            ret_out_d = 1'b1;
          end
        end
      end
      srtq_pkg::S_CPROBE: begin
        nid_d = ctr_q;
        ctr_d = ctr_nx;
        if (ctr_nx == '0) wrap_d = 1'b1;
        try_d = try_q + TryW'(1);
        if (ctr_q == '0) begin
          st_d = (try_q + TryW'(1) >= TryW'(SLOTS+2)) ? srtq_pkg::S_OUT
                                                      : srtq_pkg::S_CPROBE;
          if (try_q + TryW'(1) >= TryW'(SLOTS+2)) begin
            sk_d = srtq_pkg::K_FULL; sid_d = '0; sw_d = '0; sl_d = 1'b1;
            ret_out_d = 1'b1;
          end
        end else if (wrap_q) begin
          st_d = srtq_pkg::S_CCHK;
        end else begin
          st_d = srtq_pkg::S_INS;
        end
      end
      srtq_pkg::S_CCHK: begin
        if (!found) st_d = srtq_pkg::S_INS;
        else if (try_q >= TryW'(SLOTS+2)) begin
          sk_d = srtq_pkg::K_FULL; sid_d = '0; sw_d = '0; sl_d = 1'b1;
          ret_out_d = 1'b1; st_d = srtq_pkg::S_OUT;
        end else st_d = srtq_pkg::S_CPROBE;
      end
      srtq_pkg::S_FIND: begin
        if (!found) begin
          sk_d = srtq_pkg::K_NOTFOUND; sid_d = '0; sw_d = '0; sl_d = 1'b1;
          ret_out_d = 1'b1; st_d = srtq_pkg::S_OUT;
        end else begin
          pos_d = found_pos; nid_d = tid_q; st_d = srtq_pkg::S_RM;
        end
      end
      srtq_pkg::S_RM: begin
        cmd = srtq_pkg::C_REMOVE;
        sk_d = srtq_pkg::K_DONE; sid_d = '0; sw_d = '0; sl_d = 1'b1;
        ret_out_d = 1'b1;
        st_d = (mode_q == srtq_pkg::OP_ADJUST) ? srtq_pkg::S_INS : srtq_pkg::S_OUT;
      end
      srtq_pkg::S_INS: begin
        cmd = srtq_pkg::C_INSERT;
        if (mode_q == srtq_pkg::OP_CREATE) begin
          sk_d = srtq_pkg::K_CREATED; sid_d = 16'(nid_q); sw_d = '0;
          sl_d = 1'b1; ret_out_d = 1'b1;
        end
        st_d = srtq_pkg::S_OUT;
      end
      srtq_pkg::S_CLR: begin
        cmd = srtq_pkg::C_CLRFC;
        st_d = srtq_pkg::S_TSRCH;
      end
      srtq_pkg::S_TSRCH: begin
        if (!due || k_q >= CntW'(2*SLOTS)) begin
          sk_d = srtq_pkg::K_WAIT; sid_d = '0; sl_d = 1'b1;
          sw_d = (!empty && head_exp > now_q) ? head_exp - now_q : '0;
          ret_out_d = 1'b1; st_d = srtq_pkg::S_OUT;
        end else begin
          sk_d = srtq_pkg::K_FIRED; sid_d = 16'(due_id); sw_d = '0;
          sl_d = 1'b0; ret_out_d = 1'b0; ret_d = srtq_pkg::S_TRM;
          k_d = k_q + CntW'(1);
          pos_d = due_pos; nid_d = due_id; per_d = due_per; key_d = nx;
          nfc_d = due_fc + 2'd1;
          rep_d = (due_rep == srtq_pkg::RepForever) ? due_rep
                                                    : due_rep - srtq_pkg::RepW'(1);
          st_d = srtq_pkg::S_OUT;
        end
      end
      srtq_pkg::S_TRM: begin
        cmd = srtq_pkg::C_REMOVE;
        st_d = (rep_q == srtq_pkg::RepForever || rep_q >= 0) ? srtq_pkg::S_TINS
                                                             : srtq_pkg::S_TSRCH;
      end
      srtq_pkg::S_TINS: begin
        cmd = srtq_pkg::C_INSERT;
        st_d = srtq_pkg::S_TSRCH;
      end
      srtq_pkg::S_OUT: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          st_d = ret_out_q ? srtq_pkg::S_IDLE : ret_q;
        end
      end
      default: st_d = srtq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= srtq_pkg::S_IDLE; ov_q <= 1'b0; ctr_q <= '0; wrap_q <= 1'b0; ltt_q <= '0;
    end else begin
      st_q <= st_d; ov_q <= ov_d; ctr_q <= ctr_d; wrap_q <= wrap_d; ltt_q <= ltt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mode_q <= mode_i;
      tid_q  <= ID_BITS'(timer_id_i);
      now_q  <= now_seconds_i;
    end
    rep_q <= rep_d; per_q <= per_d; key_q <= key_d; nid_q <= nid_d; nfc_q <= nfc_d;
    try_q <= try_d; k_q <= k_d; pos_q <= pos_d; ret_out_q <= ret_out_d; ret_q <= ret_d;
    sk_q <= sk_d; sid_q <= sid_d; sw_q <= sw_d; sl_q <= sl_d;
    if (st_q == srtq_pkg::S_OUT && (!ov_q || out_ready_i)) begin
      okind_q <= sk_q; oid_q <= sid_q; owait_q <= sw_q; olast_q <= sl_q;
    end
  end

  assign out_valid_o    = ov_q;
  assign kind_o         = okind_q;
  assign result_id_o    = oid_q;
  assign wait_seconds_o = owait_q;
  assign last_item_o    = olast_q;

endmodule

// File: tb/tb_sorted_repeating_timer_queue_core.sv
// Self-checking testbench for the sorted repeating timer queue core.
// Drives create, destroy, adjust and tick beats and checks every result beat
// against a behavioral timer table kept in the testbench. Depends on srtq_pkg and sorted_repeating_timer_queue_core.
module tb_sorted_repeating_timer_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSlots = 16;
  localparam int RepGone = -1;
  localparam int RepInf = -2;
  localparam int CycleLimit = 900000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] tid;
    logic [15:0] reps;
    logic [23:0] per;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] id;
    logic [31:0] wait_s;
    logic        last;
  } res_t;

  // A directed row carries an optional expected last result typed in by hand.
  typedef struct packed {
    cmd_t cmd;
    logic has_exp;
    res_t exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = '0;
  logic [15:0] timer_id_i = '0;
  logic signed [15:0] repeat_count_i = '0;
  logic [23:0] period_i = '0;
  logic [31:0] now_seconds_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [2:0] kind_o;
  logic [15:0] result_id_o;
  logic [31:0] wait_seconds_o;
  logic last_item_o;

  sorted_repeating_timer_queue_core uut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Timer table model.
  int unsigned t_cnt;
  logic [15:0] t_id [NSlots];
  int t_rep [NSlots];
  logic [23:0] t_per [NSlots];
  logic [31:0] t_exp [NSlots];
  int t_fc [NSlots];
  logic [15:0] id_ctr;
  bit id_wrap;
  logic [31:0] last_tick;

  res_t pending_results[$];
  int errors = 0;
  bit quiet_in = 0;
  bit quiet_out = 0;

  function automatic logic [31:0] add_sat(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic int locate(logic [15:0] id);
    for (int i = 0; i < t_cnt; i++) if (t_id[i] == id) return i;
    return -1;
  endfunction

  function automatic void drop_at(int p);
    for (int i = p; i + 1 < t_cnt; i++) begin
      t_id[i] = t_id[i+1]; t_rep[i] = t_rep[i+1]; t_per[i] = t_per[i+1];
      t_exp[i] = t_exp[i+1]; t_fc[i] = t_fc[i+1];
    end
    t_cnt--;
  endfunction

  function automatic void place(logic [15:0] id, int r, logic [23:0] p,
                                logic [31:0] e, int fc);
    int pos;
    pos = t_cnt;
    for (int i = 0; i < t_cnt; i++) if (t_exp[i] > e) begin pos = i; break; end
    for (int i = t_cnt; i > pos; i--) begin
      t_id[i] = t_id[i-1]; t_rep[i] = t_rep[i-1]; t_per[i] = t_per[i-1];
      t_exp[i] = t_exp[i-1]; t_fc[i] = t_fc[i-1];
    end
    t_id[pos] = id; t_rep[pos] = r; t_per[pos] = p; t_exp[pos] = e; t_fc[pos] = fc;
    t_cnt++;
  endfunction

  function automatic res_t mk(srtq_pkg::kind_e k, logic [15:0] id, logic [31:0] w,
                              bit l);
    res_t r;
    r.kind = k; r.id = id; r.wait_s = w; r.last = l;
    return r;
  endfunction

  // Applies one command to the timer table and queues its results.
  function automatic void predict_timers(cmd_t c);
    int r, p, fired, fc;
    logic [23:0] per;
    logic [15:0] id, nid;
    logic [31:0] nx, ex, w;
    bit found, was;
    r = c.reps[15] ? RepInf : int'(c.reps);
    per = (c.per == 0) ? 24'd1 : c.per;
    case (srtq_pkg::op_e'(c.mode))
      srtq_pkg::OP_CREATE: begin
        found = 0;
        if (t_cnt < NSlots)
          for (int t = 0; t < NSlots + 2 && !found; t++) begin
            nid = id_ctr;
            id_ctr = id_ctr + 16'd1;
            was = id_wrap;
            if (id_ctr == 0) id_wrap = 1;
            if (nid == 0) continue;
            if (was && locate(nid) >= 0) continue;
            found = 1; id = nid;
          end
        if (!found) pending_results.push_back(mk(srtq_pkg::K_FULL, 0, 0, 1));
        else begin
          place(id, r, per, add_sat(last_tick, {8'd0, per}), 0);
          pending_results.push_back(mk(srtq_pkg::K_CREATED, id, 0, 1));
        end
      end
      srtq_pkg::OP_DESTROY, srtq_pkg::OP_ADJUST: begin
        p = locate(c.tid);
        if (p < 0) pending_results.push_back(mk(srtq_pkg::K_NOTFOUND, 0, 0, 1));
        else begin
          drop_at(p);
          if (srtq_pkg::op_e'(c.mode) == srtq_pkg::OP_ADJUST)
            place(c.tid, r, per, add_sat(last_tick, {8'd0, per}), 0);
          pending_results.push_back(mk(srtq_pkg::K_DONE, 0, 0, 1));
        end
      end
      default: begin
        last_tick = c.now;
        fired = 0;
        for (int i = 0; i < NSlots; i++) t_fc[i] = 0;
        forever begin
          p = -1;
          for (int i = 0; i < t_cnt; i++)
            if (t_exp[i] <= c.now && t_fc[i] < 2) begin p = i; break; end
          if (p < 0 || fired >= 2 * NSlots) break;
          id = t_id[p]; r = t_rep[p]; per = t_per[p]; ex = t_exp[p]; fc = t_fc[p];
          pending_results.push_back(mk(srtq_pkg::K_FIRED, id, 0, 0));
          fired++;
          drop_at(p);
          if (r != RepInf) begin
            r--;
            if (r <= RepGone) continue;
          end
          nx = add_sat(ex, {8'd0, per});
          if (nx < c.now) nx = add_sat(c.now, {8'd0, per});
          place(id, r, per, nx, fc + 1);
        end
        w = 0;
        if (t_cnt > 0 && t_exp[0] > c.now) w = t_exp[0] - c.now;
        pending_results.push_back(mk(srtq_pkg::K_WAIT, 0, w, 1));
      end
    endcase
  endfunction

  // One input beat; valid stays up across back-to-back beats.
  task automatic send_cmd(cmd_t c);
    if (!quiet_in)
      while ($urandom_range(99) < 15) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    in_valid_i <= 1'b1;
    mode_i <= c.mode; timer_id_i <= c.tid; repeat_count_i <= c.reps;
    period_i <= c.per; now_seconds_i <= c.now;
    do @(posedge clk_i); while (!in_ready_o);
    predict_timers(c);
    @(negedge clk_i);
  endtask

  function automatic cmd_t mkc(srtq_pkg::op_e m, logic [15:0] tid, logic [15:0] r,
                               logic [23:0] p, logic [31:0] n);
    cmd_t c;
    c.mode = m; c.tid = tid; c.reps = r; c.per = p; c.now = n;
    return c;
  endfunction

  // Receiver stalls at random, except in quiet stretches.
  always @(negedge clk_i)
    out_ready_i <= quiet_out || ($urandom_range(99) >= 15);

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with none expected: kind %0d id %0d", kind_o, result_id_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (kind_o != e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind_o); errors++;
        end
        if (result_id_o != e.id) begin
          $error("result_id: expected %0d, got %0d", e.id, result_id_o); errors++;
        end
        if (wait_seconds_o != e.wait_s) begin
          $error("wait_seconds: expected %0d, got %0d", e.wait_s, wait_seconds_o);
          errors++;
        end
        if (last_item_o != e.last) begin
          $error("last_item: expected %0d, got %0d", e.last, last_item_o); errors++;
        end
      end
    end
  end

  int unsigned cycles = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  row_t rows[$];

  function automatic void add_row(cmd_t c, bit h, res_t e);
    row_t r;
    r.cmd = c; r.has_exp = h; r.exp = e;
    rows.push_back(r);
  endfunction

  // Random command mostly aimed at live ids; ticks mostly walk forward in time, with occasional jumps and steps back.
  logic [31:0] clock_now = 0;
  function automatic cmd_t rand_cmd();
    int sel;
    logic [15:0] tid;
    logic [15:0] reps;
    logic [23:0] per;
    sel = $urandom_range(99);
    tid = (t_cnt > 0 && $urandom_range(9) < 8) ? t_id[$urandom_range(t_cnt-1)]
                                               : 16'($urandom);
    case ($urandom_range(3))
      0: reps = 16'($urandom);
      1: reps = 16'hFFFF;
      default: reps = 16'($urandom_range(3));
    endcase
    per = ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(20));
    if (sel < 35) return mkc(srtq_pkg::OP_CREATE, tid, reps, per, 0);
    if (sel < 50) return mkc(srtq_pkg::OP_DESTROY, tid, reps, per, 0);
    if (sel < 62) return mkc(srtq_pkg::OP_ADJUST, tid, reps, per, 0);
    case ($urandom_range(19))
      0: clock_now = $urandom;
      1: clock_now = 32'hFFFF_FFFF;
      2: clock_now = clock_now - $urandom_range(10);
      default: clock_now = clock_now + $urandom_range(12);
    endcase
    return mkc(srtq_pkg::OP_TICK, tid, reps, per, clock_now);
  endfunction

  initial begin
    int unsigned tail;
    t_cnt = 0; id_ctr = 0; id_wrap = 0; last_tick = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table first, then extremes and saturation.
    add_row(mkc(srtq_pkg::OP_TICK, 0, 0, 0, 0), 1, mk(srtq_pkg::K_WAIT, 0, 0, 1));
    add_row(mkc(srtq_pkg::OP_DESTROY, 16'hFFFF, 0, 1, 0), 1,
            mk(srtq_pkg::K_NOTFOUND, 0, 0, 1));
    add_row(mkc(srtq_pkg::OP_ADJUST, 0, 0, 1, 0), 1, mk(srtq_pkg::K_NOTFOUND, 0, 0, 1));
    add_row(mkc(srtq_pkg::OP_CREATE, 0, 16'h7FFF, 24'hFFFFFF, 0), 1,
            mk(srtq_pkg::K_CREATED, 1, 0, 1));
    add_row(mkc(srtq_pkg::OP_CREATE, 0, 16'h8000, 0, 0), 1,
            mk(srtq_pkg::K_CREATED, 2, 0, 1));
    add_row(mkc(srtq_pkg::OP_CREATE, 16'hFFFF, 0, 3, 32'hFFFF_FFFF), 1,
            mk(srtq_pkg::K_CREATED, 3, 0, 1));
    add_row(mkc(srtq_pkg::OP_TICK, 0, 0, 0, 1), 0, '0);
    add_row(mkc(srtq_pkg::OP_ADJUST, 2, 16'd1, 24'd2, 0), 0, '0);
    add_row(mkc(srtq_pkg::OP_TICK, 0, 0, 0, 5), 0, '0);
    add_row(mkc(srtq_pkg::OP_DESTROY, 1, 0, 1, 0), 1, mk(srtq_pkg::K_DONE, 0, 0, 1));
    add_row(mkc(srtq_pkg::OP_TICK, 0, 0, 0, 32'hFFFF_FFFE), 0, '0);
    add_row(mkc(srtq_pkg::OP_CREATE, 0, 16'hFFFF, 24'd1, 0), 0, '0);
    add_row(mkc(srtq_pkg::OP_TICK, 0, 0, 0, 32'hFFFF_FFFF), 0, '0);
    add_row(mkc(srtq_pkg::OP_TICK, 0, 0, 0, 32'hFFFF_FFFF), 0, '0);
    add_row(mkc(srtq_pkg::OP_TICK, 0, 0, 0, 3), 0, '0);
    foreach (rows[i]) begin
      if (rows[i].has_exp) begin
        send_cmd(rows[i].cmd);
        // These rows give a single result, which is the newest one queued.
        if (pending_results.size() == 0 || pending_results[$] != rows[i].exp) begin
          $error("directed row %0d: prediction differs from typed-in result", i);
          errors++;
        end
      end else send_cmd(rows[i].cmd);
    end
    clock_now = 3;

    // Fill the table until creates are refused.
    for (int i = 0; i < NSlots + 2; i++)
      send_cmd(mkc(srtq_pkg::OP_CREATE, 0, 16'($urandom_range(2)),
                   24'($urandom_range(4)), 0));
    send_cmd(mkc(srtq_pkg::OP_TICK, 0, 0, 0, 32'd8));
    clock_now = 8;

    for (int i = 0; i < 230; i++) begin
      quiet_in = (i >= 100 && i < 150);
      quiet_out = quiet_in;
      // Occasionally clear out the table so the empty case comes back often.
      if (i % 90 == 89)
        while (t_cnt > 0) send_cmd(mkc(srtq_pkg::OP_DESTROY, t_id[0], 0, 1, 0));
      send_cmd(rand_cmd());
    end
    in_valid_i <= 1'b0;
    quiet_in = 0; quiet_out = 0;

    while (pending_results.size() > 0) @(posedge clk_i);
    tail = 0;
    while (tail < 200) begin @(posedge clk_i); tail++; end
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

// File: files.f
hw/rtl/srtq_pkg.sv
hw/rtl/srtq_cell.sv
hw/rtl/srtq_chain.sv
hw/rtl/sorted_repeating_timer_queue_core.sv
tb/tb_sorted_repeating_timer_queue_core.sv
